### hdl/simple_moving_average_core_defines.svh
// Assertion macros for the simple moving average core.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef SIMPLE_MOVING_AVERAGE_CORE_DEFINES_SVH
`define SIMPLE_MOVING_AVERAGE_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SMA_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SMA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/sma_pkg.sv
// Shared widths and defaults for the simple moving average core.
// No dependencies; used by the interfaces and the top level.
package sma_pkg;

	// Signed Q16.16 sample and average width.
	localparam int SAMPLE_W = 32;
	// Width of the window length register.
	localparam int WL_W = 11;
	// Default depth of the sample ring store.
	localparam int MAX_WINDOW_DEF = 1024;

endpackage

### hdl/sma_if.sv
// Valid/ready channel interfaces of the simple moving average core.
// Depends on sma_pkg for the payload widths.

// Configuration write channel: one beat writes the window length.
interface sma_cfg_if;
	import sma_pkg::*;
	logic            valid;
	logic            ready;
	logic [WL_W-1:0] window_length;
	modport source(output valid, output window_length, input ready);
	modport sink(input valid, input window_length, output ready);
endinterface

// Sample channel: one beat carries one Q16.16 sample.
interface sma_sample_if;
	import sma_pkg::*;
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample_value;
	modport source(output valid, output sample_value, input ready);
	modport sink(input valid, input sample_value, output ready);
endinterface

// Average channel: one beat carries one Q16.16 window mean.
interface sma_average_if;
	import sma_pkg::*;
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] average_value;
	modport source(output valid, output average_value, input ready);
	modport sink(input valid, input average_value, output ready);
endinterface

### hdl/sma_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module sma_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### hdl/simple_moving_average_core.sv
// Simple moving average core: mean of the last window_length Q16.16 samples.
// Depends on sma_pkg, sma_if.sv, sma_ram and simple_moving_average_core_defines.svh.
//
// Channels: cfg writes the window length (1..MAX_WINDOW, zero reads as one,
// larger values saturate); samples carries one signed Q16.16 sample per beat;
// averages returns exactly one signed Q16.16 mean per sample beat, truncated
// toward zero. Every config beat restarts the filter, and the first sample
// after a restart fills the whole window with its own value.
// Timing: a sample beat is followed by the ring read and sum update (S_UPDATE),
// divider setup (S_PREP) and a radix-2 restoring divider (S_DIV); the mean is
// registered on leaving S_DONE. samples.ready rises at that same edge, so the
// core takes no new sample until the mean of the previous one is registered.
// A finished mean sits in an output register; the next sample is taken while
// it waits. If the receiver still stalls when the following mean is done, the
// core holds in its final state until the output register frees up.
// A pending config beat holds off the sample channel for that cycle.
// Reset: window length 1, filter restarted, no mean pending. The ring store
// needs no clearing pass; entries are read only after they were written.
`include "simple_moving_average_core_defines.svh"

module simple_moving_average_core #(
	parameter int MAX_WINDOW = sma_pkg::MAX_WINDOW_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	sma_cfg_if.sink              cfg,
	sma_sample_if.sink           samples,
	sma_average_if.source        averages
);
	import sma_pkg::*;

	localparam int IDX_W = $clog2(MAX_WINDOW);
	localparam int SUM_W = SAMPLE_W + IDX_W;
	localparam int CNT_W = $clog2(SUM_W);
	localparam int REM_W = WL_W + 1;
	localparam int PROD_W = SAMPLE_W + WL_W + 1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_UPDATE,
		S_PREP,
		S_DIV,
		S_DONE
	} state_t;

	state_t                     state_q;
	logic [WL_W-1:0]            win_len_q;
	logic [IDX_W-1:0]           write_index_q;
	logic signed [SUM_W-1:0]    sum_q;
	logic signed [SAMPLE_W-1:0] seed_q;
	logic signed [SAMPLE_W-1:0] sample_q;
	logic                       awaiting_first_q;
	logic                       has_wrapped_q;
	logic [SUM_W-1:0]           dvd_q;
	logic [WL_W-1:0]            rem_q;
	logic [CNT_W-1:0]           cnt_q;
	logic                       neg_q;
	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] out_data_q;

	logic                       sample_beat;
	logic                       cfg_beat;
	logic [WL_W-1:0]            cfg_len;
	logic [SAMPLE_W-1:0]        ram_rd_data;
	logic signed [SAMPLE_W-1:0] old_value;
	logic signed [SAMPLE_W:0]   sample_diff;
	logic signed [PROD_W-1:0]   seed_prod;
	logic                       index_wraps;
	logic [REM_W-1:0]           trial;
	logic                       trial_ge;
	logic [SAMPLE_W-1:0]        quot;
	logic                       out_free;

	// Handshakes; a config beat takes precedence over a sample beat.
	assign sample_beat = samples.valid && samples.ready;
	assign cfg_beat = cfg.valid && cfg.ready;
	assign samples.ready = (state_q == S_IDLE) && !cfg.valid;
	assign cfg.ready = (state_q == S_IDLE);
	assign averages.valid = out_valid_q;
	assign averages.average_value = out_data_q;
	assign out_free = !out_valid_q || averages.ready;

	// Window length as written, with zero raised to one and large values saturated.
	always_comb begin
		cfg_len = cfg.window_length;
		if (cfg.window_length == '0) begin
			cfg_len = WL_W'(1);
		end else if (32'(cfg.window_length) > 32'(MAX_WINDOW)) begin
			cfg_len = WL_W'(MAX_WINDOW);
		end
	end

	// Ring store of past samples; read at the sample beat, written in the update cycle.
	sma_ram #(
		.WIDTH(SAMPLE_W),
		.DEPTH(MAX_WINDOW)
	) u_ring (
		.clk    (clk),
		.wr_en  (state_q == S_UPDATE),
		.wr_addr(write_index_q),
		.wr_data(sample_q),
		.rd_en  (sample_beat),
		.rd_addr(write_index_q),
		.rd_data(ram_rd_data)
	);

	// Running sum update: the seed stands in for the oldest sample until the first wrap.
	assign old_value = has_wrapped_q ? $signed(ram_rd_data) : seed_q;
	assign sample_diff = {sample_q[SAMPLE_W-1], sample_q} - {old_value[SAMPLE_W-1], old_value};
	assign seed_prod = sample_q * $signed({1'b0, win_len_q});
	assign index_wraps = (32'(write_index_q) + 32'd1) >= 32'(win_len_q);

	// One step of the restoring divider on the sum magnitude.
	assign trial = {rem_q, dvd_q[SUM_W-1]};
	assign trial_ge = trial >= {1'b0, win_len_q};
	assign quot = dvd_q[SAMPLE_W-1:0];

	// Sequencer, filter state and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			win_len_q <= WL_W'(1);
			write_index_q <= '0;
			sum_q <= '0;
			seed_q <= '0;
			sample_q <= '0;
			awaiting_first_q <= 1'b1;
			has_wrapped_q <= 1'b0;
			dvd_q <= '0;
			rem_q <= '0;
			cnt_q <= '0;
			neg_q <= 1'b0;
			out_valid_q <= 1'b0;
			out_data_q <= '0;
		end else begin
			// The output register fills when a mean is done and empties at an output beat.
			if ((state_q == S_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (averages.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cfg_beat) begin
						win_len_q <= cfg_len;
						write_index_q <= '0;
						sum_q <= '0;
						seed_q <= '0;
						awaiting_first_q <= 1'b1;
						has_wrapped_q <= 1'b0;
					end else if (sample_beat) begin
						sample_q <= samples.sample_value;
						state_q <= S_UPDATE;
					end
				end
				S_UPDATE: begin
					if (awaiting_first_q) begin
						seed_q <= sample_q;
						sum_q <= SUM_W'(seed_prod);
						awaiting_first_q <= 1'b0;
					end else begin
						sum_q <= sum_q + SUM_W'(sample_diff);
					end
					if (index_wraps) begin
						write_index_q <= '0;
						has_wrapped_q <= 1'b1;
					end else begin
						write_index_q <= write_index_q + IDX_W'(1);
					end
					state_q <= S_PREP;
				end
				S_PREP: begin
					neg_q <= sum_q[SUM_W-1];
					dvd_q <= sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
					rem_q <= '0;
					cnt_q <= CNT_W'(SUM_W - 1);
					state_q <= S_DIV;
				end
				S_DIV: begin
					rem_q <= trial_ge ? WL_W'(trial - {1'b0, win_len_q}) : trial[WL_W-1:0];
					dvd_q <= {dvd_q[SUM_W-2:0], trial_ge};
					cnt_q <= cnt_q - CNT_W'(1);
					if (cnt_q == '0) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_data_q <= neg_q ? $signed(-quot) : $signed(quot);
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// The write index always stays inside the current window.
	`SMA_ASSERT_SAME(a_index_in_window, 1'b1, 32'(write_index_q) < 32'(win_len_q), "index out")

	// A restarted filter has no history.
	`SMA_ASSERT_SAME(a_restart_clean, awaiting_first_q, (write_index_q == '0) && !has_wrapped_q, "history")

	// A sample beat makes the core busy until its mean is done.
	`SMA_ASSERT_NEXT(a_busy_after_beat, sample_beat, !samples.ready && (state_q == S_UPDATE), "not busy")

	// The last divider step hands over to the output stage.
	`SMA_ASSERT_NEXT(a_div_ends, (state_q == S_DIV) && (cnt_q == '0), state_q == S_DONE, "divider did not finish")

endmodule
